### hw/rtl/htd_pkg.sv
// Shared constants and codes for the code-tree decoder.
package htd_pkg;

   // Store size and code length bound
   localparam int NODE_COUNT_DEF = 512;
   localparam int MAX_CODE_LEN   = 32;
   localparam int CODE_W         = 32;
   localparam int LEN_W          = 6;
   localparam int BUDGET_W       = 63;

   // Request actions
   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_BUDGET = 2'd2;
   localparam logic [1:0] ACT_DECODE = 2'd3;

   // Response kinds
   localparam logic [2:0] KIND_SYMBOL = 3'd0;
   localparam logic [2:0] KIND_ACK    = 3'd1;
   localparam logic [2:0] KIND_REJECT = 3'd2;
   localparam logic [2:0] KIND_ERROR  = 3'd3;
   localparam logic [2:0] KIND_DONE   = 3'd4;

endpackage

### hw/rtl/huffman_tree_decoder.sv
// Top level of the code-tree decoder: node store, tree walker and response register.
// One request beat is taken at a time; req_stall is high while a beat is being worked.
// Clear tree and set budget go straight to the closing beat. An insert of a legal length
// takes the beat, steps once per code bit (following an existing node or hanging a new
// one), ends the walk, writes the symbol and responds. For each valid bit a decode
// makes a walk step and a leaf test: the walk step issues a read of the
// child in the node store (one read port, registered data) and the next cycle tests
// that child for a leaf. Response beats wait in an output register while rsp_stall
// is high. The root node lives in flip-flops; no clearing pass is needed after reset.
module huffman_tree_decoder
   import htd_pkg::*;
#(
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic [7:0]          req_symbol,
   input  logic [LEN_W-1:0]    req_code_length,
   input  logic [CODE_W-1:0]   req_code_bits,
   input  logic [BUDGET_W-1:0] req_symbol_count,
   input  logic [7:0]          req_data_byte,
   input  logic [3:0]          req_valid_bits,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_kind,
   output logic [7:0]          rsp_decoded_symbol,
   output logic [3:0]          rsp_consumed_bits,
   output logic                rsp_budget_empty,
   output logic                rsp_last
);

   localparam int IW = $clog2(NODE_COUNT);
   localparam int NW = IW + 1;
   localparam int SW = ((NW > LEN_W) ? NW : LEN_W) + 1;

   typedef struct packed {
      logic [IW-1:0] zero;
      logic [IW-1:0] one;
      logic [7:0]    sym;
   } node_rec_type;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_RESP      = 3'd1;
   localparam logic [2:0] S_INS_WALK  = 3'd2;
   localparam logic [2:0] S_INS_ALLOC = 3'd3;
   localparam logic [2:0] S_DEC       = 3'd4;
   localparam logic [2:0] S_DEC_LEAF  = 3'd5;

   // Node store
   node_rec_type mem [NODE_COUNT];
   node_rec_type rd_q_ff;
   logic [IW-1:0] rd_addr;
   logic          mem_we;
   logic [IW-1:0] mem_wa;
   node_rec_type  mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_q_ff <= mem[rd_addr];
   end

   // Control and working registers
   logic [2:0]          state_ff, state_in;
   logic [IW-1:0]       walk_ff, walk_in;
   logic [IW-1:0]       cur_ff, cur_in;
   logic [NW-1:0]       nf_ff, nf_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   node_rec_type        root_ff, root_in;
   node_rec_type        rec_ff, rec_in;
   logic [7:0]          sym_ff, sym_in;
   logic [CODE_W-1:0]   code_ff, code_in;
   logic [LEN_W-1:0]    rem_ff, rem_in;
   logic [7:0]          byte_ff, byte_in;
   logic [3:0]          nb_ff, nb_in;
   logic [3:0]          idx_ff, idx_in;
   logic [2:0]          pend_ff, pend_in;

   // Response register
   logic       out_v_ff, out_v_in;
   logic [2:0] out_kind_ff, out_kind_in;
   logic [7:0] out_sym_ff, out_sym_in;
   logic [3:0] out_used_ff, out_used_in;
   logic       out_empty_ff, out_empty_in;
   logic       out_last_ff, out_last_in;

   logic          out_free;
   logic          accept;
   node_rec_type  ins_rec, dec_rec, wr_rec;
   logic [LEN_W-1:0] pos;
   logic          ins_bit, dec_bit;
   logic [IW-1:0] ins_c, dec_c;
   logic [SW-1:0] need_sum;

   assign out_free  = !out_v_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   assign ins_rec = (cur_ff == '0) ? root_ff : rd_q_ff;
   assign dec_rec = (walk_ff == '0) ? root_ff : rd_q_ff;
   assign pos     = rem_ff - LEN_W'(1);
   assign ins_bit = (pos < LEN_W'(CODE_W)) ? code_ff[pos[4:0]] : 1'b0;
   assign dec_bit = byte_ff[~idx_ff[2:0]];
   assign ins_c   = ins_bit ? ins_rec.one : ins_rec.zero;
   assign dec_c   = dec_bit ? dec_rec.one : dec_rec.zero;
   assign need_sum = SW'(nf_ff) + SW'(rem_ff);

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      walk_in   = walk_ff;
      cur_in    = cur_ff;
      nf_in     = nf_ff;
      budget_in = budget_ff;
      root_in   = root_ff;
      rec_in    = rec_ff;
      sym_in    = sym_ff;
      code_in   = code_ff;
      rem_in    = rem_ff;
      byte_in   = byte_ff;
      nb_in     = nb_ff;
      idx_in    = idx_ff;
      pend_in   = pend_ff;
      mem_we    = 1'b0;
      mem_wa    = cur_ff;
      mem_wd    = rec_ff;
      wr_rec    = rec_ff;
      rd_addr   = walk_ff;

      out_v_in     = rsp_stall ? out_v_ff : 1'b0;
      out_kind_in  = out_kind_ff;
      out_sym_in   = out_sym_ff;
      out_used_in  = out_used_ff;
      out_empty_in = out_empty_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pend_in = KIND_ACK;
               case (req_action)
                  ACT_CLEAR: begin
                     root_in  = '0;
                     nf_in    = NW'(1);
                     walk_in  = '0;
                     state_in = S_RESP;
                  end
                  ACT_INSERT: begin
                     sym_in  = req_symbol;
                     code_in = req_code_bits;
                     rem_in  = req_code_length;
                     cur_in  = '0;
                     if (req_code_length == '0 ||
                         req_code_length > LEN_W'(MAX_CODE_LEN)) begin
                        pend_in  = KIND_REJECT;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_INS_WALK;
                     end
                  end
                  ACT_BUDGET: begin
                     budget_in = req_symbol_count;
                     walk_in   = '0;
                     state_in  = S_RESP;
                  end
                  default: begin
                     byte_in  = req_data_byte;
                     nb_in    = (req_valid_bits > 4'd8) ? 4'd8 : req_valid_bits;
                     idx_in   = '0;
                     state_in = S_DEC;
                  end
               endcase
            end
         end

         // Single closing beat (ack or reject)
         S_RESP: begin
            if (out_free) begin
               out_v_in     = 1'b1;
               out_kind_in  = pend_ff;
               out_sym_in   = '0;
               out_used_in  = '0;
               out_empty_in = (budget_ff == '0);
               out_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end

         // Follow existing nodes; stop at a missing child or the code end, or reject if the store lacks room
         S_INS_WALK: begin
            rd_addr = ins_c;
            rec_in  = ins_rec;
            if (rem_ff == '0) begin
               state_in = S_INS_ALLOC;
            end else if (ins_c == '0) begin
               if (need_sum > SW'(NODE_COUNT)) begin
                  pend_in  = KIND_REJECT;
                  state_in = S_RESP;
               end else begin
                  state_in = S_INS_ALLOC;
               end
            end else begin
               cur_in = ins_c;
               rem_in = rem_ff - LEN_W'(1);
            end
         end

         // Hang a fresh node per remaining bit, then write the symbol
         S_INS_ALLOC: begin
            if (rem_ff == '0) begin
               wr_rec.sym = sym_ff;
               pend_in    = KIND_ACK;
               state_in   = S_RESP;
            end else begin
               if (ins_bit) begin
                  wr_rec.one = nf_ff[IW-1:0];
               end else begin
                  wr_rec.zero = nf_ff[IW-1:0];
               end
               cur_in = nf_ff[IW-1:0];
               rec_in = '0;
               nf_in  = nf_ff + NW'(1);
               rem_in = rem_ff - LEN_W'(1);
            end
            if (cur_ff == '0) begin
               root_in = wr_rec;
            end else begin
               mem_we = 1'b1;
               mem_wd = wr_rec;
            end
         end

         // One stream bit: step to the child, finish the byte or report a missing child
         // (the read port stays on the walk node while a closing beat waits)
         S_DEC: begin
            if (idx_ff == nb_ff || budget_ff == '0) begin
               if (out_free) begin
                  out_v_in     = 1'b1;
                  out_kind_in  = KIND_DONE;
                  out_sym_in   = '0;
                  out_used_in  = idx_ff;
                  out_empty_in = (budget_ff == '0);
                  out_last_in  = 1'b1;
                  state_in     = S_IDLE;
               end
            end else if (dec_c == '0) begin
               if (out_free) begin
                  walk_in      = '0;
                  out_v_in     = 1'b1;
                  out_kind_in  = KIND_ERROR;
                  out_sym_in   = '0;
                  out_used_in  = idx_ff;
                  out_empty_in = 1'b0;
                  out_last_in  = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               rd_addr  = dec_c;
               walk_in  = dec_c;
               idx_in   = idx_ff + 4'd1;
               state_in = S_DEC_LEAF;
            end
         end

         // Leaf test on the node just reached
         S_DEC_LEAF: begin
            if (rd_q_ff.zero == '0 && rd_q_ff.one == '0) begin
               if (out_free) begin
                  budget_in    = budget_ff - BUDGET_W'(1);
                  walk_in      = '0;
                  out_v_in     = 1'b1;
                  out_kind_in  = KIND_SYMBOL;
                  out_sym_in   = rd_q_ff.sym;
                  out_used_in  = '0;
                  out_empty_in = (budget_ff == BUDGET_W'(1));
                  out_last_in  = 1'b0;
                  state_in     = S_DEC;
               end
            end else begin
               state_in = S_DEC;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         walk_ff   <= '0;
         nf_ff     <= NW'(1);
         budget_ff <= '0;
         root_ff   <= '0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         walk_ff   <= walk_in;
         nf_ff     <= nf_in;
         budget_ff <= budget_in;
         root_ff   <= root_in;
         out_v_ff  <= out_v_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      rec_ff       <= rec_in;
      sym_ff       <= sym_in;
      code_ff      <= code_in;
      rem_ff       <= rem_in;
      byte_ff      <= byte_in;
      nb_ff        <= nb_in;
      idx_ff       <= idx_in;
      pend_ff      <= pend_in;
      out_kind_ff  <= out_kind_in;
      out_sym_ff   <= out_sym_in;
      out_used_ff  <= out_used_in;
      out_empty_ff <= out_empty_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_kind           = out_kind_ff;
   assign rsp_decoded_symbol = out_sym_ff;
   assign rsp_consumed_bits  = out_used_ff;
   assign rsp_budget_empty   = out_empty_ff;
   assign rsp_last           = out_last_ff;

endmodule

### hw/rtl/htd_checker.sv
// Port-level checks for the code-tree decoder, bound to the top level.
module htd_checker
   import htd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_kind,
   input logic [3:0] rsp_consumed_bits,
   input logic       rsp_last
);

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_last))
      else $error("response beat changed while stalled");

   // Symbol beats never close an item; every other kind does
   a_sym_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_SYMBOL |-> !rsp_last)
      else $error("symbol beat marked last");

   a_other_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_SYMBOL |-> rsp_last)
      else $error("closing beat not marked last");

   // Never more than one byte of bits consumed
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_consumed_bits <= 4'd8)
      else $error("consumed bit count out of range");

   // Nothing pending straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("activity right after reset");

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (.*);
